// File: src/fjrm_pkg.sv
// fjrm_pkg: item types and opcode constants of the forward jump register machine
// used by the execute unit, the top level and the port checker; no dependencies
package fjrm_pkg;

    // opcodes
    localparam logic [3:0] OP_NOP  = 4'd0;
    localparam logic [3:0] OP_ADD  = 4'd1;
    localparam logic [3:0] OP_MOVC = 4'd2;
    localparam logic [3:0] OP_RETX = 4'd3;
    localparam logic [3:0] OP_RETC = 4'd4;
    localparam logic [3:0] OP_JMP  = 4'd5;
    localparam logic [3:0] OP_EQ   = 4'd6;
    localparam logic [3:0] OP_GT   = 4'd7;
    localparam logic [3:0] OP_GE   = 4'd8;
    localparam logic [3:0] OP_LT   = 4'd9;
    localparam logic [3:0] OP_LE   = 4'd10;
    localparam logic [3:0] OP_MAXC = 4'd11;
    localparam logic [3:0] OP_MAXX = 4'd12;

    // item modes
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_INSTR = 1'b1;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] start_value;
        logic [3:0]         opcode;
        logic [1:0]         dest_reg;
        logic [1:0]         src_reg;
        logic signed [31:0] imm_value;
        logic [3:0]         jump_offset;
        logic               last_instr;
    } instr_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               by_return;
    } result_t;

    // machine state seen by the execute unit
    typedef struct packed {
        logic       halted;
        logic [3:0] skip;
        logic       at_limit;
    } fjrm_state_t;

    // control decisions of the execute unit
    typedef struct packed {
        logic       start;
        logic       wr_en;
        logic       emit;
        logic       by_return;
        logic       halted_next;
        logic [3:0] skip_next;
        logic       count_inc;
    } fjrm_ctrl_t;

endpackage

// File: src/forward_jump_register_machine.sv
// forward_jump_register_machine: top level, input register, execute step, result register
// depends on fjrm_pkg, fjrm_ram and fjrm_exec
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+-------------------------------
//  instr    | in        | instr_valid / instr_ready  | instr_t: start or instruction
//  result   | out       | result_valid / result_ready| result_t: value and return flag
//
//  one item per cycle unless an emitting item waits for the result register; an item is
//  captured in the input register and executed there; its result, if any, is registered
//  the register file lives in a ram whose read is started as the item is captured,
//  with a one-entry bypass for the write of the previous item
//  reset puts the machine in the halted state with all registers reading zero
//  a result waiting in the result register stalls only an item that itself emits
module forward_jump_register_machine
    import fjrm_pkg::*;
#(
    parameter int REG_COUNT    = 4,
    parameter int PROG_LEN_MAX = 16,
    parameter int DATA_WIDTH   = 32
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    instr_valid,
    output logic    instr_ready,
    input  instr_t  instr,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    localparam int RIDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int CNT_W  = $clog2(PROG_LEN_MAX + 1);

    // register index taken modulo the register count; the raw index is below four,
    // so for two or more registers a single compare and subtract is enough
    function automatic logic [RIDX_W-1:0] reg_index(input logic [1:0] raw);
        logic [1:0] m;
        m = raw;
        if (int'(raw) >= REG_COUNT)
        begin
            m = raw - 2'(REG_COUNT);
        end
        return RIDX_W'(m);
    endfunction

    // input register
    logic   stg_valid_reg;
    instr_t stg_item_reg;

    // machine state
    logic [REG_COUNT-1:0]  vld_reg;
    logic [DATA_WIDTH-1:0] r0_reg;
    logic [3:0]            skip_reg;
    logic                  halted_reg;
    logic [CNT_W-1:0]      cnt_reg;

    // bypass of the last ram write
    logic                  fwd_vld_reg;
    logic [RIDX_W-1:0]     fwd_addr_reg;
    logic [DATA_WIDTH-1:0] fwd_data_reg;

    // result register
    logic    out_valid_reg;
    result_t out_item_reg;

    logic                  in_accept;
    logic                  out_free;
    logic                  exec_go;
    logic [RIDX_W-1:0]     stg_d;
    logic [RIDX_W-1:0]     stg_s;
    logic [RIDX_W-1:0]     raddr_a;
    logic [RIDX_W-1:0]     raddr_b;
    logic [DATA_WIDTH-1:0] rd_a;
    logic [DATA_WIDTH-1:0] rd_b;
    logic [DATA_WIDTH-1:0] opa;
    logic [DATA_WIDTH-1:0] opb;
    fjrm_state_t           st;
    fjrm_ctrl_t            ctrl;
    logic [RIDX_W-1:0]     wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [DATA_WIDTH-1:0] res_data;
    logic                  ram_we;

    assign out_free    = !out_valid_reg || result_ready;
    // only an emitting item has to wait for the result register
    assign exec_go     = stg_valid_reg && (!ctrl.emit || out_free);
    assign instr_ready = !stg_valid_reg || exec_go;
    assign in_accept   = instr_valid && instr_ready;

    assign stg_d = reg_index(stg_item_reg.dest_reg);
    assign stg_s = reg_index(stg_item_reg.src_reg);

    // read at the incoming item's indexes, or keep refreshing the held item's ones
    assign raddr_a = in_accept ? reg_index(instr.dest_reg) : stg_d;
    assign raddr_b = in_accept ? reg_index(instr.src_reg)  : stg_s;

    assign ram_we = exec_go && ctrl.wr_en;

    fjrm_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (REG_COUNT)
    ) u_rf (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (wr_addr),
        .wdata   (wr_data),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    // entry not written since the last start reads as zero
    always_comb
    begin
        opa = '0;
        opb = '0;
        if (vld_reg[stg_d])
        begin
            opa = (fwd_vld_reg && fwd_addr_reg == stg_d) ? fwd_data_reg : rd_a;
        end
        if (vld_reg[stg_s])
        begin
            opb = (fwd_vld_reg && fwd_addr_reg == stg_s) ? fwd_data_reg : rd_b;
        end
    end

    assign st.halted   = halted_reg;
    assign st.skip     = skip_reg;
    assign st.at_limit = (cnt_reg >= CNT_W'(PROG_LEN_MAX - 1));

    fjrm_exec #(
        .DATA_WIDTH (DATA_WIDTH),
        .RIDX_W     (RIDX_W)
    ) u_exec (
        .item     (stg_item_reg),
        .st       (st),
        .d_idx    (stg_d),
        .opa      (opa),
        .opb      (opb),
        .r0       (r0_reg),
        .ctrl     (ctrl),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .res_data (res_data)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            stg_valid_reg <= 1'b1;
        end
        else if (exec_go)
        begin
            stg_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            stg_item_reg <= instr;
        end
    end

    // machine state, advanced once per executed item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            r0_reg      <= '0;
            skip_reg    <= '0;
            halted_reg  <= 1'b1;
            cnt_reg     <= '0;
            fwd_vld_reg <= 1'b0;
        end
        else
        begin
            fwd_vld_reg <= ram_we;
            if (exec_go)
            begin
                skip_reg   <= ctrl.skip_next;
                halted_reg <= ctrl.halted_next;
                if (ctrl.start)
                begin
                    // start writes register 0, all others read as zero again
                    vld_reg <= REG_COUNT'(1);
                    cnt_reg <= '0;
                end
                else
                begin
                    if (ctrl.wr_en)
                    begin
                        vld_reg <= vld_reg | (REG_COUNT'(1) << wr_addr);
                    end
                    if (ctrl.count_inc)
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                if (ctrl.wr_en && wr_addr == '0)
                begin
                    r0_reg <= wr_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_we)
        begin
            fwd_addr_reg <= wr_addr;
            fwd_data_reg <= wr_data;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (exec_go && ctrl.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_go && ctrl.emit)
        begin
            out_item_reg.result_value <= 32'(res_data);
            out_item_reg.by_return    <= ctrl.by_return;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

endmodule

// File: src/fjrm_ram.sv
// fjrm_ram: generic ram, one write port and two read ports with registered read data
// no dependencies
module fjrm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
    output logic [WIDTH-1:0]                         rdata_a,
    output logic [WIDTH-1:0]                         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_a_reg;
    logic [WIDTH-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rd_a_reg <= mem_reg[raddr_a];
        rd_b_reg <= mem_reg[raddr_b];
    end

    assign rdata_a = rd_a_reg;
    assign rdata_b = rd_b_reg;

endmodule

// File: src/fjrm_exec.sv
// fjrm_exec: combinational execute step for one item of the register machine
// depends on fjrm_pkg for item types, state and control structs, opcodes
module fjrm_exec
    import fjrm_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int RIDX_W     = 2
) (
    input  instr_t                  item,
    input  fjrm_state_t             st,
    input  logic [RIDX_W-1:0]       d_idx,
    input  logic [DATA_WIDTH-1:0]   opa,
    input  logic [DATA_WIDTH-1:0]   opb,
    input  logic [DATA_WIDTH-1:0]   r0,
    output fjrm_ctrl_t              ctrl,
    output logic [RIDX_W-1:0]       wr_addr,
    output logic [DATA_WIDTH-1:0]   wr_data,
    output logic [DATA_WIDTH-1:0]   res_data
);

    logic [DATA_WIDTH-1:0] imm_x;
    logic [DATA_WIDTH-1:0] start_x;
    logic                  take;
    logic                  last;

    assign imm_x   = DATA_WIDTH'($signed(item.imm_value));
    assign start_x = DATA_WIDTH'($signed(item.start_value));
    assign last    = item.last_instr | st.at_limit;

    always_comb
    begin
        ctrl             = '0;
        ctrl.halted_next = st.halted;
        ctrl.skip_next   = st.skip;
        wr_addr          = d_idx;
        wr_data          = '0;
        res_data         = r0;
        take             = 1'b0;

        if (item.mode == MODE_START)
        begin
            ctrl.start       = 1'b1;
            ctrl.wr_en       = 1'b1;
            wr_addr          = '0;
            wr_data          = start_x;
            ctrl.halted_next = 1'b0;
            ctrl.skip_next   = '0;
        end
        else if (!st.halted)
        begin
            ctrl.count_inc = 1'b1;
            if (st.skip != 4'd0)
            begin
                // discarded by an earlier jump
                ctrl.skip_next = st.skip - 4'd1;
                if (last)
                begin
                    ctrl.emit = 1'b1;
                end
            end
            else
            begin
                unique case (item.opcode)
                    OP_ADD:
                    begin
                        ctrl.wr_en = 1'b1;
                        wr_data    = opa + opb;
                    end
                    OP_MOVC:
                    begin
                        ctrl.wr_en = 1'b1;
                        wr_data    = imm_x;
                    end
                    OP_RETX:
                    begin
                        ctrl.emit      = 1'b1;
                        ctrl.by_return = 1'b1;
                        res_data       = opa;
                    end
                    OP_RETC:
                    begin
                        ctrl.emit      = 1'b1;
                        ctrl.by_return = 1'b1;
                        res_data       = imm_x;
                    end
                    OP_JMP: take = 1'b1;
                    OP_EQ:  take = (opa == opb);
                    OP_GT:  take = ($signed(opa) > $signed(opb));
                    OP_GE:  take = ($signed(opa) >= $signed(opb));
                    OP_LT:  take = ($signed(opa) < $signed(opb));
                    OP_LE:  take = ($signed(opa) <= $signed(opb));
                    OP_MAXC:
                    begin
                        ctrl.wr_en = 1'b1;
                        wr_data    = ($signed(opa) < $signed(imm_x)) ? imm_x : opa;
                    end
                    OP_MAXX:
                    begin
                        ctrl.wr_en = 1'b1;
                        wr_data    = ($signed(opa) < $signed(opb)) ? opb : opa;
                    end
                    default: ;
                endcase

                if (take)
                begin
                    ctrl.skip_next = item.jump_offset;
                end

                // end of program: register 0 as it stands after this instruction
                if (!ctrl.emit && last)
                begin
                    ctrl.emit = 1'b1;
                    res_data  = (ctrl.wr_en && wr_addr == '0) ? wr_data : r0;
                end
            end

            if (ctrl.emit)
            begin
                ctrl.halted_next = 1'b1;
            end
        end
    end

endmodule

// File: src/fjrm_checker.sv
// fjrm_checker: port level assertions for the forward jump register machine
// depends on fjrm_pkg; bound to forward_jump_register_machine at the end of this file
module fjrm_checker
    import fjrm_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input logic    clk,
    input logic    rst_n,
    input logic    instr_valid,
    input logic    instr_ready,
    input instr_t  instr,
    input logic    result_valid,
    input logic    result_ready,
    input result_t result
);

    logic acc;

    assign acc = instr_valid && instr_ready;

    // a stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // with an empty result register the input side never stalls
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> instr_ready)
        else $error("input stalled with empty result register");

    // a start item emits nothing
    a_start_silent: assert property (@(posedge clk) disable iff (!rst_n)
        acc && instr.mode == MODE_START |-> ##2 !$rose(result_valid))
        else $error("start item produced a result");

    // return constant right after a start comes out flagged as a return, carrying its constant
    a_retc_first: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && instr.mode == MODE_START) ##1
        (acc && instr.mode == MODE_INSTR && instr.opcode == OP_RETC && !result_valid)
        |=> ##1 (result_valid && result.by_return &&
                 (DATA_WIDTH < 32 || result.result_value == $past(instr.imm_value, 2))))
        else $error("return constant result wrong or late");

endmodule

bind forward_jump_register_machine fjrm_checker #(.DATA_WIDTH(DATA_WIDTH)) u_fjrm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .instr_valid  (instr_valid),
    .instr_ready  (instr_ready),
    .instr        (instr),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
